// File: hdl/color_sensor_frequency_to_rgb_defines.svh
// Assertion helpers shared by the queue and back-end modules.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef COLOR_SENSOR_FREQUENCY_TO_RGB_DEFINES_SVH
`define COLOR_SENSOR_FREQUENCY_TO_RGB_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/csf_pkg.sv
package csf_pkg;

  // Fixed field widths.
  localparam int GATE_BITS      = 16;
  localparam int SCALE_BITS     = 10;
  localparam int HZ_BITS        = 24;
  localparam int VALUE_BITS     = 8;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;
  // Width of 255 * (hz - min), the dividend of the color mapping.
  localparam int NUM_BITS       = HZ_BITS + VALUE_BITS;

  localparam logic [HZ_BITS-1:0]    HZ_MAX    = 24'hFFFFFF;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = 8'd255;

  // Color channel codes.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Sensor filter select codes.
  localparam logic [1:0] FILTER_RED   = 2'h0;
  localparam logic [1:0] FILTER_GREEN = 2'h3;
  localparam logic [1:0] FILTER_BLUE  = 2'h1;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_GATE_MS   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HZ_SCALE  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RED_MIN   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RED_MAX   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_MIN = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_MAX = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_MIN  = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_MAX  = 3'd7;

  // Register reset values.
  localparam logic [GATE_BITS-1:0]  RST_GATE_MS   = 16'd100;
  localparam logic [SCALE_BITS-1:0] RST_HZ_SCALE  = 10'd10;
  localparam logic [HZ_BITS-1:0]    RST_RED_MIN   = 24'd6000;
  localparam logic [HZ_BITS-1:0]    RST_RED_MAX   = 24'd100000;
  localparam logic [HZ_BITS-1:0]    RST_GREEN_MIN = 24'd5000;
  localparam logic [HZ_BITS-1:0]    RST_GREEN_MAX = 24'd60000;
  localparam logic [HZ_BITS-1:0]    RST_BLUE_MIN  = 24'd6000;
  localparam logic [HZ_BITS-1:0]    RST_BLUE_MAX  = 24'd95000;

  // Settings the scaling back end reads.
  typedef struct packed {
    logic [SCALE_BITS-1:0] hz_scale;
    logic [HZ_BITS-1:0]    red_min;
    logic [HZ_BITS-1:0]    red_max;
    logic [HZ_BITS-1:0]    green_min;
    logic [HZ_BITS-1:0]    green_max;
    logic [HZ_BITS-1:0]    blue_min;
    logic [HZ_BITS-1:0]    blue_max;
  } csf_cfg_t;

  // Channels run red, green, blue, then back to red.
  function automatic logic [1:0] next_channel(input logic [1:0] ch);
    logic [1:0] nxt;
    case (ch)
      CH_RED:   nxt = CH_GREEN;
      CH_GREEN: nxt = CH_BLUE;
      default:  nxt = CH_RED;
    endcase
    return nxt;
  endfunction

  function automatic logic [1:0] filter_code(input logic [1:0] ch);
    logic [1:0] code;
    case (ch)
      CH_RED:   code = FILTER_RED;
      CH_GREEN: code = FILTER_GREEN;
      default:  code = FILTER_BLUE;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/color_sensor_frequency_to_rgb.sv
// Throughput: one sensor sample per clock; the input stalls only when two gate
// results are queued behind the scaling unit.
// A closed gate passes through the queue, then the MUL, PREP and CHK states; a clamped
// or range-error result then skips the shift-subtract divider, any other runs it.
// Reset: synchronous active-low; counters clear, channel returns to red and the
// registers take their default gate, scale and range values.
module color_sensor_frequency_to_rgb #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_pulse_level,
  input  logic                                  in_ms_tick,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_channel,
  output logic [csf_pkg::HZ_BITS-1:0]           out_measured_hz,
  output logic [csf_pkg::VALUE_BITS-1:0]        out_color_value,
  output logic                                  out_clamped,
  output logic                                  out_range_error,
  output logic [1:0]                            out_next_filter_select,
  output logic                                  out_last_of_frame,
  input  logic                                  cfg_we,
  input  logic [csf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [csf_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
  import csf_pkg::*;

  logic [GATE_BITS-1:0]  gate_ms_r;
  csf_cfg_t              cfg_r;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_push;
  logic                  q_pop;
  logic [COUNT_BITS+1:0] q_wdata;
  logic [COUNT_BITS+1:0] q_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_ms_r       <= RST_GATE_MS;
      cfg_r.hz_scale  <= RST_HZ_SCALE;
      cfg_r.red_min   <= RST_RED_MIN;
      cfg_r.red_max   <= RST_RED_MAX;
      cfg_r.green_min <= RST_GREEN_MIN;
      cfg_r.green_max <= RST_GREEN_MAX;
      cfg_r.blue_min  <= RST_BLUE_MIN;
      cfg_r.blue_max  <= RST_BLUE_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GATE_MS:   gate_ms_r       <= cfg_wdata[GATE_BITS-1:0];
        REG_HZ_SCALE:  cfg_r.hz_scale  <= cfg_wdata[SCALE_BITS-1:0];
        REG_RED_MIN:   cfg_r.red_min   <= cfg_wdata[HZ_BITS-1:0];
        REG_RED_MAX:   cfg_r.red_max   <= cfg_wdata[HZ_BITS-1:0];
        REG_GREEN_MIN: cfg_r.green_min <= cfg_wdata[HZ_BITS-1:0];
        REG_GREEN_MAX: cfg_r.green_max <= cfg_wdata[HZ_BITS-1:0];
        REG_BLUE_MIN:  cfg_r.blue_min  <= cfg_wdata[HZ_BITS-1:0];
        REG_BLUE_MAX:  cfg_r.blue_max  <= cfg_wdata[HZ_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sampling front end: edge counting and gate timing.
  csf_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pulse_level (in_pulse_level),
    .ms_tick     (in_ms_tick),
    .gate_ms     (gate_ms_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Closed gates waiting for scaling.
  csf_queue #(
    .WIDTH (COUNT_BITS + 2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Frequency scaling and color mapping.
  csf_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .q_empty                (q_empty),
    .q_data                 (q_rdata),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_channel            (out_channel),
    .out_measured_hz        (out_measured_hz),
    .out_color_value        (out_color_value),
    .out_clamped            (out_clamped),
    .out_range_error        (out_range_error),
    .out_next_filter_select (out_next_filter_select),
    .out_last_of_frame      (out_last_of_frame)
  );
endmodule

// File: hdl/csf_queue.sv
module csf_queue #(
  parameter int WIDTH = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  `include "color_sensor_frequency_to_rgb_defines.svh"

  localparam int DEPTH     = 2;
  localparam int PTR_BITS  = 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entry_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;

  assign full     = (count_r == CNT_BITS'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `CSF_ASSERT_NOW(a_no_push_full, push, !full, "push into a full queue")
  `CSF_ASSERT_NOW(a_no_pop_empty, pop, !empty, "pop from an empty queue")
  `CSF_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after a push")
endmodule

// File: hdl/csf_front.sv
module csf_front #(
  parameter int COUNT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              pulse_level,
  input  logic                              ms_tick,
  input  logic [csf_pkg::GATE_BITS-1:0]     gate_ms,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [COUNT_BITS+1:0]             q_data
);
  import csf_pkg::*;

  logic                  prev_level_r;
  logic [COUNT_BITS-1:0] edge_count_r;
  logic [GATE_BITS-1:0]  elapsed_r;
  logic [1:0]            channel_r;

  logic                  accept;
  logic                  rise;
  logic [COUNT_BITS-1:0] count_nxt;
  logic [GATE_BITS-1:0]  elapsed_inc;
  logic [GATE_BITS-1:0]  gate_len;
  logic                  gate_close;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Rising edge count, saturating at the counter's full scale.
  assign rise      = pulse_level && !prev_level_r;
  assign count_nxt = (rise && (edge_count_r != '1)) ? edge_count_r + 1'b1 : edge_count_r;

  // Gate timing: a zero gate length behaves as one tick.
  assign gate_len    = (gate_ms == '0) ? GATE_BITS'(1) : gate_ms;
  assign elapsed_inc = elapsed_r + 1'b1;
  assign gate_close  = ms_tick && !((elapsed_inc < gate_len) && (elapsed_inc != '0));

  // A closed gate hands its channel and edge count to the back end.
  assign q_push = accept && gate_close;
  assign q_data = {channel_r, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      edge_count_r <= '0;
      elapsed_r    <= '0;
      channel_r    <= CH_RED;
    end else if (accept) begin
      prev_level_r <= pulse_level;
      if (gate_close) begin
        edge_count_r <= '0;
        elapsed_r    <= '0;
        channel_r    <= next_channel(channel_r);
      end else begin
        edge_count_r <= count_nxt;
        if (ms_tick) begin
          elapsed_r <= elapsed_inc;
        end
      end
    end
  end
endmodule

// File: hdl/csf_back.sv
module csf_back #(
  parameter int COUNT_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  csf_pkg::csf_cfg_t                  cfg,
  input  logic                               q_empty,
  input  logic [COUNT_BITS+1:0]              q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_channel,
  output logic [csf_pkg::HZ_BITS-1:0]        out_measured_hz,
  output logic [csf_pkg::VALUE_BITS-1:0]     out_color_value,
  output logic                               out_clamped,
  output logic                               out_range_error,
  output logic [1:0]                         out_next_filter_select,
  output logic                               out_last_of_frame
);
  import csf_pkg::*;
  `include "color_sensor_frequency_to_rgb_defines.svh"

  localparam int PROD_BITS = COUNT_BITS + SCALE_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state_r;
  logic [2:0]            state_nxt;
  logic [1:0]            ch_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [PROD_BITS-1:0]  prod_r;
  logic [HZ_BITS-1:0]    hz_r;
  logic [HZ_BITS-1:0]    diff_r;
  logic [HZ_BITS-1:0]    div_r;
  logic                  err_r;
  logic                  below_r;
  logic [NUM_BITS-1:0]   rem_r;
  logic [VALUE_BITS-1:0] q_r;
  logic                  clamp_r;
  logic [2:0]            step_r;
  logic                  out_valid_r;

  logic [HZ_BITS-1:0]    hz_sat;
  logic [HZ_BITS-1:0]    lo;
  logic [HZ_BITS-1:0]    hi;
  logic [NUM_BITS-1:0]   num;
  logic                  over;
  logic [NUM_BITS-1:0]   shifted;
  logic                  fits;
  logic                  load_out;

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Saturated frequency and the bounds of the channel in hand.
  assign hz_sat = (prod_r > PROD_BITS'(HZ_MAX)) ? HZ_MAX : prod_r[HZ_BITS-1:0];

  always_comb begin
    case (ch_r)
      CH_RED: begin
        lo = cfg.red_min;
        hi = cfg.red_max;
      end
      CH_GREEN: begin
        lo = cfg.green_min;
        hi = cfg.green_max;
      end
      default: begin
        lo = cfg.blue_min;
        hi = cfg.blue_max;
      end
    endcase
  end

  // Dividend 255 * (hz - min); a quotient above 255 clamps.
  assign num  = NUM_BITS'({diff_r, 8'h00}) - NUM_BITS'(diff_r);
  assign over = (num >= NUM_BITS'({div_r, 8'h00}));

  // One quotient bit per cycle, most significant first.
  assign shifted = NUM_BITS'(div_r) << step_r;
  assign fits    = (rem_r >= shifted);

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = q_empty ? S_IDLE : S_MUL;
      S_MUL:   state_nxt = S_PREP;
      S_PREP:  state_nxt = S_CHK;
      S_CHK:   state_nxt = (err_r || below_r || over) ? S_DONE : S_DIV;
      S_DIV:   state_nxt = (step_r == '0) ? S_DONE : S_DIV;
      S_DONE:  state_nxt = load_out ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ch_r  <= q_data[COUNT_BITS+1:COUNT_BITS];
        cnt_r <= q_data[COUNT_BITS-1:0];
      end
      S_MUL: begin
        prod_r <= PROD_BITS'(cnt_r) * PROD_BITS'(cfg.hz_scale);
      end
      S_PREP: begin
        hz_r    <= hz_sat;
        err_r   <= (hi <= lo);
        below_r <= (hz_sat < lo);
        diff_r  <= hz_sat - lo;
        div_r   <= hi - lo;
      end
      S_CHK: begin
        rem_r  <= num;
        step_r <= 3'd7;
        if (err_r) begin
          q_r     <= '0;
          clamp_r <= 1'b0;
        end else if (below_r) begin
          q_r     <= '0;
          clamp_r <= 1'b1;
        end else if (over) begin
          q_r     <= VALUE_MAX;
          clamp_r <= 1'b1;
        end else begin
          q_r     <= '0;
          clamp_r <= 1'b0;
        end
      end
      S_DIV: begin
        if (fits) begin
          rem_r <= rem_r - shifted;
        end
        q_r    <= {q_r[VALUE_BITS-2:0], fits};
        step_r <= step_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_channel            <= ch_r;
      out_measured_hz        <= hz_r;
      out_color_value        <= q_r;
      out_clamped            <= clamp_r;
      out_range_error        <= err_r;
      out_next_filter_select <= filter_code(next_channel(ch_r));
      out_last_of_frame      <= (ch_r == CH_BLUE);
    end
  end

  assign out_valid = out_valid_r;

  `CSF_ASSERT_NOW(a_div_nonzero, state_r == S_DIV, div_r != '0, "division by zero range")
  `CSF_ASSERT_NEXT(a_done_loads, load_out, out_valid, "finished word not presented")
  `CSF_ASSERT_NOW(a_pop_idle, q_pop, state_r == S_IDLE, "queue popped while busy")
endmodule

// File: dv/color_sensor_frequency_to_rgb_tb.sv
`timescale 1ns / 1ps

module color_sensor_frequency_to_rgb_tb;
  import csf_pkg::*;

  localparam int     COUNT_BITS    = 24;
  localparam int     NUM_REGS      = 8;
  localparam int     SETTLE_CYCLES = 32;
  localparam longint CYCLE_LIMIT   = 2000000;

  // One color word as it leaves the block.
  typedef struct packed {
    logic [1:0]            channel;
    logic [HZ_BITS-1:0]    hz;
    logic [VALUE_BITS-1:0] value;
    logic                  clamped;
    logic                  range_error;
    logic [1:0]            filter;
    logic                  last;
  } color_word_t;

  typedef enum {READY_ALWAYS, READY_COIN, READY_RARE} ready_style_t;

  // Tracks the gate counter and channel sequence and holds the color words still owed.
  class color_scoreboard;
    logic [GATE_BITS-1:0]  gate_len;
    logic [SCALE_BITS-1:0] scale;
    logic [HZ_BITS-1:0]    ch_lo [3];
    logic [HZ_BITS-1:0]    ch_hi [3];
    logic                  prev_level;
    logic [COUNT_BITS-1:0] edges;
    logic [GATE_BITS-1:0]  elapsed;
    logic [1:0]            chan;
    color_word_t           owed_colors [$];
    int                    mismatches;

    function new();
      gate_len   = RST_GATE_MS;
      scale      = RST_HZ_SCALE;
      ch_lo[0]   = RST_RED_MIN;
      ch_hi[0]   = RST_RED_MAX;
      ch_lo[1]   = RST_GREEN_MIN;
      ch_hi[1]   = RST_GREEN_MAX;
      ch_lo[2]   = RST_BLUE_MIN;
      ch_hi[2]   = RST_BLUE_MAX;
      prev_level = 1'b0;
      edges      = '0;
      elapsed    = '0;
      chan       = CH_RED;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_GATE_MS:   gate_len = data[GATE_BITS-1:0];
        REG_HZ_SCALE:  scale = data[SCALE_BITS-1:0];
        REG_RED_MIN:   ch_lo[0] = data;
        REG_RED_MAX:   ch_hi[0] = data;
        REG_GREEN_MIN: ch_lo[1] = data;
        REG_GREEN_MAX: ch_hi[1] = data;
        REG_BLUE_MIN:  ch_lo[2] = data;
        default:       ch_hi[2] = data;
      endcase
    endfunction

    // Counts edges and, when the gate closes, works out the color word it owes.
    function void take_sample(logic level, logic tick);
      logic [GATE_BITS-1:0]             span;
      logic [1:0]                       ch;
      logic [1:0]                       nxt;
      logic [COUNT_BITS+SCALE_BITS-1:0] product;
      logic [HZ_BITS-1:0]               hz;
      logic [HZ_BITS-1:0]               lo;
      logic [HZ_BITS-1:0]               hi;
      logic [NUM_BITS-1:0]              quotient;
      color_word_t                      w;
      if (level && !prev_level && edges != {COUNT_BITS{1'b1}}) begin
        edges = edges + 1'b1;
      end
      prev_level = level;
      if (!tick) return;
      span = (gate_len == '0) ? 16'd1 : gate_len;
      elapsed = elapsed + 1'b1;
      if (elapsed < span && elapsed != '0) return;

      ch = (chan > CH_BLUE) ? CH_BLUE : chan;
      product = (COUNT_BITS+SCALE_BITS)'(edges) * (COUNT_BITS+SCALE_BITS)'(scale);
      hz = (product > (COUNT_BITS+SCALE_BITS)'(HZ_MAX)) ? HZ_MAX : product[HZ_BITS-1:0];
      lo = ch_lo[ch];
      hi = ch_hi[ch];
      w.value = '0;
      w.clamped = 1'b0;
      w.range_error = 1'b0;
      if (hi <= lo) begin
        w.range_error = 1'b1;
      end else if (hz < lo) begin
        w.clamped = 1'b1;
      end else begin
        quotient = (NUM_BITS'(VALUE_MAX) * NUM_BITS'(hz - lo)) / NUM_BITS'(hi - lo);
        if (quotient > NUM_BITS'(VALUE_MAX)) begin
          w.value = VALUE_MAX;
          w.clamped = 1'b1;
        end else begin
          w.value = quotient[VALUE_BITS-1:0];
        end
      end

      nxt = (ch == CH_BLUE) ? CH_RED : ch + 1'b1;
      case (nxt)
        CH_RED:   w.filter = FILTER_RED;
        CH_GREEN: w.filter = FILTER_GREEN;
        default:  w.filter = FILTER_BLUE;
      endcase
      w.channel = ch;
      w.hz = hz;
      w.last = (ch == CH_BLUE);
      owed_colors.push_back(w);
      chan = nxt;
      edges = '0;
      elapsed = '0;
    endfunction

    function void same(string field, longint unsigned want, longint unsigned got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_color(color_word_t got);
      color_word_t want;
      if (owed_colors.size() == 0) begin
        $error("color word with none expected: channel %0d hz %0d", got.channel, got.hz);
        mismatches++;
        return;
      end
      want = owed_colors.pop_front();
      same("channel", want.channel, got.channel);
      same("measured_hz", want.hz, got.hz);
      same("color_value", want.value, got.value);
      same("clamped", want.clamped, got.clamped);
      same("range_error", want.range_error, got.range_error);
      same("next_filter_select", want.filter, got.filter);
      same("last_of_frame", want.last, got.last);
    endfunction

    function int pending();
      return owed_colors.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_pulse_level = 1'b0;
  logic                        in_ms_tick = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  out_channel;
  logic [HZ_BITS-1:0]          out_measured_hz;
  logic [VALUE_BITS-1:0]       out_color_value;
  logic                        out_clamped;
  logic                        out_range_error;
  logic [1:0]                  out_next_filter_select;
  logic                        out_last_of_frame;
  logic                        cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]    cfg_wdata = '0;

  color_scoreboard             board = new();
  logic [CFG_DATA_BITS-1:0]    reg_val [NUM_REGS];
  int                          burst_left = 0;
  int                          stall_left = 0;
  ready_style_t                ready_style = READY_ALWAYS;
  longint                      cycles = 0;

  color_sensor_frequency_to_rgb #(
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_pulse_level        (in_pulse_level),
    .in_ms_tick            (in_ms_tick),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_channel           (out_channel),
    .out_measured_hz       (out_measured_hz),
    .out_color_value       (out_color_value),
    .out_clamped           (out_clamped),
    .out_range_error       (out_range_error),
    .out_next_filter_select(out_next_filter_select),
    .out_last_of_frame     (out_last_of_frame),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver holds off on a pattern that is picked anew whenever stall_left runs out.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        ready_style = ready_style_t'($urandom_range(0, 2));
        stall_left = $urandom_range(50, 300);
      end
      stall_left--;
      case (ready_style)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default:      out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Every accepted word, accepted sample and register write goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        board.check_color({out_channel, out_measured_hz, out_color_value, out_clamped,
                           out_range_error, out_next_filter_select, out_last_of_frame});
      end
      if (in_valid && in_ready) begin
        board.take_sample(in_pulse_level, in_ms_tick);
      end
      if (cfg_we) begin
        board.write_reg(cfg_index, cfg_wdata);
      end
    end
  end

  // Sends one sample word; the sender runs in bursts with idle gaps between them.
  task automatic push_sample(input logic lvl, input logic tick);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 32);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pulse_level <= lvl;
    in_ms_tick <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Waits until every owed word has come out and the scaling unit has gone quiet.
  // The first edge lets the last accepted sample reach the scoreboard.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all registers; bits above the gate and scale widths carry junk.
  task automatic apply_settings();
    logic [CFG_DATA_BITS-1:0] junk;
    for (int i = 0; i < NUM_REGS; i++) begin
      junk = CFG_DATA_BITS'($urandom());
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_INDEX_BITS-1:0];
      if (i == REG_GATE_MS) begin
        cfg_wdata <= {junk[CFG_DATA_BITS-1:GATE_BITS], reg_val[i][GATE_BITS-1:0]};
      end else if (i == REG_HZ_SCALE) begin
        cfg_wdata <= {junk[CFG_DATA_BITS-1:SCALE_BITS], reg_val[i][SCALE_BITS-1:0]};
      end else begin
        cfg_wdata <= reg_val[i];
      end
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_range(input int c, input logic [HZ_BITS-1:0] lo,
                           input logic [HZ_BITS-1:0] hi);
    reg_val[REG_RED_MIN + 2 * c] = lo;
    reg_val[REG_RED_MAX + 2 * c] = hi;
  endtask

  // Each pair of samples makes one rising edge and leaves the line high.
  task automatic feed_edges(input int n);
    for (int i = 0; i < n; i++) begin
      push_sample(1'b0, 1'b0);
      push_sample(1'b1, 1'b0);
    end
  endtask

  // Square wave of the given half period with ticks at random, optionally with glitches.
  task automatic random_phase(input int count, input int half, input int tick_div,
                              input bit noisy);
    logic lvl;
    logic flip;
    logic tick;
    int   run;
    lvl = 1'b0;
    run = half;
    for (int i = 0; i < count; i++) begin
      if (run == 0) begin
        lvl = ~lvl;
        run = half;
      end
      run--;
      flip = noisy && ($urandom_range(0, 9) == 0);
      tick = ($urandom_range(1, tick_div) == 1);
      push_sample(lvl ^ flip, tick);
    end
  endtask

  // Random settings: short gates, ranges mostly within reach of the edge counts.
  task automatic pick_settings();
    logic [HZ_BITS-1:0] lo;
    logic [HZ_BITS-1:0] hi;
    reg_val[REG_GATE_MS] = CFG_DATA_BITS'(($urandom_range(0, 9) == 0) ? 0
                                                                      : $urandom_range(1, 6));
    case ($urandom_range(0, 7))
      0:       reg_val[REG_HZ_SCALE] = 24'd0;
      1:       reg_val[REG_HZ_SCALE] = 24'd1000;
      default: reg_val[REG_HZ_SCALE] = CFG_DATA_BITS'($urandom_range(1, 1000));
    endcase
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(0, 7))
        0: begin
          lo = HZ_BITS'($urandom());
          hi = HZ_BITS'($urandom());
        end
        1: begin
          lo = HZ_BITS'($urandom_range(0, 20000));
          hi = HZ_BITS'(lo - $urandom_range(0, lo));
        end
        default: begin
          lo = HZ_BITS'($urandom_range(0, 15000));
          hi = HZ_BITS'(lo + $urandom_range(1, 25000));
        end
      endcase
      set_range(c, lo, hi);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one tick per gate, unit scale, tiny red range, bad green and blue ranges.
    reg_val[REG_GATE_MS] = 24'd1;
    reg_val[REG_HZ_SCALE] = 24'd1;
    set_range(0, 24'd2, 24'd4);
    set_range(1, 24'd3, 24'd3);
    set_range(2, 24'd5, 24'd1);
    apply_settings();
    // Red exactly at min, its last edge on the closing sample.
    feed_edges(1);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b1);
    // Green with max equal to min, blue with max below min.
    push_sample(1'b0, 1'b1);
    push_sample(1'b1, 1'b1);
    // Red exactly at max.
    feed_edges(4);
    push_sample(1'b0, 1'b1);
    push_sample(1'b0, 1'b1);
    push_sample(1'b0, 1'b1);
    // Red below min.
    feed_edges(1);
    push_sample(1'b0, 1'b1);
    push_sample(1'b0, 1'b1);
    push_sample(1'b0, 1'b1);
    // Red above max.
    feed_edges(5);
    push_sample(1'b0, 1'b1);
    settle();

    // Zero gate acts as one tick, zero scale, widest ranges.
    reg_val[REG_GATE_MS] = 24'd0;
    reg_val[REG_HZ_SCALE] = 24'd0;
    for (int c = 0; c < 3; c++) set_range(c, 24'd0, HZ_MAX);
    apply_settings();
    random_phase(120, 1, 3, 1'b1);
    settle();

    // Longest gate at a scale of 1000: no tick closes it, so the edges carry over.
    reg_val[REG_GATE_MS] = 24'hFFFF;
    reg_val[REG_HZ_SCALE] = 24'd1000;
    set_range(0, 24'd0, HZ_MAX);
    set_range(1, HZ_MAX, HZ_MAX);
    set_range(2, HZ_MAX - 1'b1, HZ_MAX);
    apply_settings();
    random_phase(400, 1, 4, 1'b0);
    settle();
    // Shortening the gate closes it on the next tick without a restart.
    reg_val[REG_GATE_MS] = 24'd1;
    apply_settings();
    push_sample(1'b0, 1'b1);
    random_phase(60, 1, 2, 1'b1);
    settle();

    // Random phases, each under its own settings.
    for (int p = 0; p < 8; p++) begin
      pick_settings();
      apply_settings();
      random_phase(200, $urandom_range(1, 4), $urandom_range(2, 10), 1'b1);
      settle();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
